[hw/rtl/lruwb_pkg.sv]
// shared types and constants for the lru write-back cache directory
// no dependencies
package lruwb_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TAG_W        = 32;
  localparam int STAMP_W      = 64;
  localparam int COUNT_W      = 32;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_WRITEBACK = 2'd0,
    ACT_FETCH     = 2'd1,
    ACT_COMPLETE  = 2'd2,
    ACT_UNUSED    = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [TAG_W-1:0] block_num;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [TAG_W-1:0]   target_block;
    logic               was_hit;
    logic               last;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
  } out_item_t;

  // contents of one directory cell
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
    logic               dirty;
  } entry_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic               found;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    logic               dirty;
  } tok_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic               evict;
    logic               install;
    logic               install_dirty;
    logic               touch;
    logic               set_dirty;
    logic               clean;
    logic               mode_dirty;
    logic [TAG_W-1:0]   req_tag;
    logic [STAMP_W-1:0] stamp_new;
  } cell_ctl_t;

endpackage

[hw/rtl/lruwb_cell.sv]
// one directory cell: holds an entry, shifts down on eviction, and
// forwards the running lru / first-dirty search token to its neighbor
// depends on lruwb_pkg
module lruwb_cell import lruwb_pkg::*; #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] sel_idx,
  input  entry_t           up_entry,
  input  tok_t             tok_in,
  input  logic [IDX_W-1:0] idx_in,
  output entry_t           entry,
  output tok_t             tok_out,
  output logic [IDX_W-1:0] idx_out,
  output logic             match
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic shift_in;
  logic load;
  logic take;

  assign match    = entry.valid && (entry.tag == ctl.req_tag);
  assign shift_in = ctl.evict && (MY_IDX >= sel_idx);
  assign load     = ctl.install && (MY_IDX == sel_idx);

  always_comb begin
    if (ctl.mode_dirty) begin
      take = entry.valid && entry.dirty && !tok_in.found;
    end else begin
      // strict compare keeps the lowest entry on equal stamps
      take = entry.valid && (!tok_in.found || (entry.stamp < tok_in.stamp));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift_in) begin
      entry <= up_entry;
    end else if (load) begin
      entry.valid <= 1'b1;
      entry.tag   <= ctl.req_tag;
      entry.stamp <= ctl.stamp_new;
      entry.dirty <= ctl.install_dirty;
    end else if (ctl.touch && match) begin
      entry.stamp <= ctl.stamp_new;
      if (ctl.set_dirty) begin
        entry.dirty <= 1'b1;
      end
    end else if (ctl.clean && (MY_IDX == sel_idx)) begin
      entry.dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_out <= '{found: 1'b1, stamp: entry.stamp, tag: entry.tag, dirty: entry.dirty};
      idx_out <= MY_IDX;
    end else begin
      tok_out <= tok_in;
      idx_out <= idx_in;
    end
  end

endmodule

[hw/rtl/lru_writeback_block_cache_directory_unit.sv]
// lru write-back cache directory: sequencer plus a chain of CAPACITY cells
// a miss on a full directory first runs an lru search that ripples through the
// cell chain; a flush repeats a first-dirty search after each dirty entry it
// writes back; one transaction in work at a time
// reset clears cell valid bits, entry count, stamp counter and hit/miss counts
// depends on lruwb_pkg and lruwb_cell
module lru_writeback_block_cache_directory_unit import lruwb_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(CAPACITY - 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LOOKUP  = 8'b0000_0010,
    S_SCAN    = 8'b0000_0100,
    S_EVICT   = 8'b0000_1000,
    S_FETCH   = 8'b0001_0000,
    S_INSTALL = 8'b0010_0000,
    S_FWB     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t             state, state_next;
  logic [1:0]         op, op_next;
  logic [TAG_W-1:0]   req_tag, req_tag_next;
  logic               was_hit, was_hit_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [STAMP_W-1:0] stamp_ctr, stamp_ctr_next;
  logic [COUNT_W-1:0] hits, hits_next;
  logic [COUNT_W-1:0] misses, misses_next;
  logic [IDX_W-1:0]   scan_cnt, scan_cnt_next;
  logic               scan_dirty, scan_dirty_next;
  out_item_t          out_reg, out_reg_next;
  logic               out_v_next;

  cell_ctl_t          ctl;
  logic [IDX_W-1:0]   sel_idx;
  entry_t             entries [CAPACITY];
  tok_t               toks    [CAPACITY];
  logic [IDX_W-1:0]   idxs    [CAPACITY];
  logic [CAPACITY-1:0] match_vec;

  logic out_free;
  logic hit;
  logic in_acc;
  tok_t last_tok;

  assign out_free  = !out_valid || !out_stall;
  assign hit       = |match_vec;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && (state == S_IDLE);
  assign last_tok  = toks[CAPACITY-1];
  assign out_item  = out_reg;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      entry_t           up_e;
      tok_t             t_in;
      logic [IDX_W-1:0] i_in;
      if (g == CAPACITY - 1) begin : g_top
        assign up_e = '0;
      end else begin : g_mid
        assign up_e = entries[g+1];
      end
      if (g == 0) begin : g_first
        assign t_in = '0;
        assign i_in = '0;
      end else begin : g_rest
        assign t_in = toks[g-1];
        assign i_in = idxs[g-1];
      end
      lruwb_cell #(.IDX(g), .IDX_W(IDX_W)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .sel_idx  (sel_idx),
        .up_entry (up_e),
        .tok_in   (t_in),
        .idx_in   (i_in),
        .entry    (entries[g]),
        .tok_out  (toks[g]),
        .idx_out  (idxs[g]),
        .match    (match_vec[g])
      );
    end
  endgenerate

  always_comb begin
    state_next      = state;
    op_next         = op;
    req_tag_next    = req_tag;
    was_hit_next    = was_hit;
    count_next      = count;
    stamp_ctr_next  = stamp_ctr;
    hits_next       = hits;
    misses_next     = misses;
    scan_cnt_next   = scan_cnt;
    scan_dirty_next = scan_dirty;
    out_reg_next    = out_reg;
    out_v_next      = out_valid && out_stall;

    ctl               = '0;
    ctl.req_tag       = req_tag;
    ctl.stamp_new     = stamp_ctr + STAMP_W'(1);
    ctl.mode_dirty    = scan_dirty;
    ctl.install_dirty = (op == FUNC_WRITE);
    ctl.set_dirty     = (op == FUNC_WRITE);
    sel_idx           = '0;

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          op_next      = in_item.func;
          req_tag_next = in_item.block_num;
          was_hit_next = 1'b0;
          unique case (in_item.func) inside
            FUNC_READ, FUNC_WRITE: state_next = S_LOOKUP;
            FUNC_FLUSH: begin
              scan_dirty_next = 1'b1;
              scan_cnt_next   = '0;
              state_next      = S_SCAN;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_LOOKUP: begin
        if (hit) begin
          ctl.touch      = 1'b1;
          stamp_ctr_next = stamp_ctr + STAMP_W'(1);
          was_hit_next   = 1'b1;
          if (op == FUNC_READ && hits != '1) begin
            hits_next = hits + COUNT_W'(1);
          end
          state_next = S_DONE;
        end else begin
          was_hit_next = 1'b0;
          if (op == FUNC_READ && misses != '1) begin
            misses_next = misses + COUNT_W'(1);
          end
          if (count == FULL) begin
            scan_dirty_next = 1'b0;
            scan_cnt_next   = '0;
            state_next      = S_SCAN;
          end else begin
            state_next = (op == FUNC_READ) ? S_FETCH : S_INSTALL;
          end
        end
      end
      S_SCAN: begin
        // wait for the token to ripple through every cell
        if (scan_cnt == SCAN_END) begin
          state_next = (op == FUNC_FLUSH) ? S_FWB : S_EVICT;
        end else begin
          scan_cnt_next = scan_cnt + IDX_W'(1);
        end
      end
      S_EVICT: begin
        if (!last_tok.dirty || out_free) begin
          if (last_tok.dirty) begin
            out_v_next   = 1'b1;
            out_reg_next = '{action: ACT_WRITEBACK, target_block: last_tok.tag,
                             was_hit: 1'b0, last: 1'b0,
                             hit_count: hits, miss_count: misses};
          end
          ctl.evict  = 1'b1;
          sel_idx    = idxs[CAPACITY-1];
          count_next = count - CNT_W'(1);
          state_next = (op == FUNC_READ) ? S_FETCH : S_INSTALL;
        end
      end
      S_FETCH: begin
        if (out_free) begin
          out_v_next   = 1'b1;
          out_reg_next = '{action: ACT_FETCH, target_block: req_tag,
                           was_hit: 1'b0, last: 1'b0,
                           hit_count: hits, miss_count: misses};
          state_next   = S_INSTALL;
        end
      end
      S_INSTALL: begin
        ctl.install    = 1'b1;
        sel_idx        = count[IDX_W-1:0];
        stamp_ctr_next = stamp_ctr + STAMP_W'(1);
        count_next     = count + CNT_W'(1);
        state_next     = S_DONE;
      end
      S_FWB: begin
        if (!last_tok.found) begin
          state_next = S_DONE;
        end else if (out_free) begin
          out_v_next    = 1'b1;
          out_reg_next  = '{action: ACT_WRITEBACK, target_block: last_tok.tag,
                            was_hit: 1'b0, last: 1'b0,
                            hit_count: hits, miss_count: misses};
          ctl.clean     = 1'b1;
          sel_idx       = idxs[CAPACITY-1];
          scan_cnt_next = '0;
          state_next    = S_SCAN;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_v_next   = 1'b1;
          out_reg_next = '{action: ACT_COMPLETE,
                           target_block: (op == FUNC_READ || op == FUNC_WRITE) ?
                                         req_tag : '0,
                           was_hit: was_hit, last: 1'b1,
                           hit_count: hits, miss_count: misses};
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      stamp_ctr  <= '0;
      hits       <= '0;
      misses     <= '0;
      out_valid  <= 1'b0;
      scan_cnt   <= '0;
      scan_dirty <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      stamp_ctr  <= stamp_ctr_next;
      hits       <= hits_next;
      misses     <= misses_next;
      out_valid  <= out_v_next;
      scan_cnt   <= scan_cnt_next;
      scan_dirty <= scan_dirty_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    req_tag <= req_tag_next;
    was_hit <= was_hit_next;
    out_reg <= out_reg_next;
  end

endmodule
